/* hdl/sprite_pixel_expander_defines.svh */
// Assertion macros for the sprite pixel expander checker.
// No dependencies; included by files that assert.
`ifndef SPRITE_PIXEL_EXPANDER_DEFINES_SVH
`define SPRITE_PIXEL_EXPANDER_DEFINES_SVH

// checked only outside reset
`define SPE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define SPE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/spe_pkg.sv */
// Shared types and constants of the sprite pixel expander.
// No dependencies.
`default_nettype none
package spe_pkg;

   localparam int SPRITE_ROWS_DEF   = 21;
   localparam int BYTES_PER_ROW_DEF = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_MULTICOLOR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DBL_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DBL_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPR_COLOR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_A    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_B    = 3'd5;

   localparam logic [3:0] COLOR_A_RST = 4'hA;
   localparam logic [3:0] COLOR_B_RST = 4'hD;
   localparam logic [7:0] COLOR_BG    = 8'hFF;

   typedef struct packed {
      logic       multicolor;
      logic       dbl_w;
      logic       dbl_h;
      logic [3:0] spr_color;
      logic [3:0] color_a;
      logic [3:0] color_b;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data;
      logic [2:0] col_lo;
      logic [5:0] row_lo;
      logic       sprite_end;
   } job_type;

   typedef struct packed {
      logic [5:0] pos_x;
      logic [5:0] pos_y;
      logic [7:0] color;
      logic       foreground;
      logic       transparent;
      logic       last;
      logic       sprite_end;
   } pix_type;

endpackage
`default_nettype wire

/* hdl/spe_front.sv */
// Front end: takes data bytes, tracks the byte position, tags each job.
// Depends on spe_pkg.
`default_nettype none
module spe_front #(
   parameter int SPRITE_ROWS   = 21,
   parameter int BYTES_PER_ROW = 3
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire logic [7:0]      data_byte,
   input  wire logic            sprite_start,
   output spe_pkg::job_type     job
);
   import spe_pkg::*;

   localparam int RW = (SPRITE_ROWS > 1) ? $clog2(SPRITE_ROWS) : 1;
   localparam int CW = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
   localparam logic [RW-1:0] ROW_LAST = RW'(SPRITE_ROWS - 1);
   localparam logic [CW-1:0] COL_LAST = CW'(BYTES_PER_ROW - 1);

   logic [RW-1:0] row_ff, row_in, row_cur;
   logic [CW-1:0] col_ff, col_in, col_cur;
   logic [RW+5:0] row_ext;
   logic [CW+2:0] col_ext;
   logic          row_end, col_end;

   always_comb begin
      row_cur = sprite_start ? '0 : row_ff;
      col_cur = sprite_start ? '0 : col_ff;
      row_end = (row_cur == ROW_LAST);
      col_end = (col_cur == COL_LAST);
      row_in  = row_ff;
      col_in  = col_ff;
      if (push) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_cur + 1'b1;
         end else begin
            col_in = col_cur + 1'b1;
            row_in = row_cur;
         end
      end
      row_ext        = {6'b0, row_cur};
      col_ext        = {3'b0, col_cur};
      job.data       = data_byte;
      job.col_lo     = col_ext[2:0];
      job.row_lo     = row_ext[5:0];
      job.sprite_end = row_end && col_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/spe_fifo.sv */
// Two-entry job queue between front and back end.
// Depends on spe_pkg.
`default_nettype none
module spe_fifo (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  spe_pkg::job_type push_job,
   output logic             full,
   input  wire logic        pop,
   output logic             empty,
   output spe_pkg::job_type head_job
);
   import spe_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == 2'd2);
      empty     = (count_ff == 2'd0);
      head_job  = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/spe_back.sv */
// Back end: steps through the pixel writes of one job, one per cycle unless
// the result stage is held, into a registered result stage. Depends on spe_pkg.
`default_nettype none
module spe_back (
   input  wire logic        clock,
   input  wire logic        reset,
   input  spe_pkg::cfg_type cfg,
   input  wire logic        job_valid,
   input  spe_pkg::job_type job,
   output logic             job_done,
   output logic             out_valid,
   input  wire logic        out_pop,
   output spe_pkg::pix_type out_pix
);
   import spe_pkg::*;

   logic [2:0] px_ff, px_in;
   logic       dy_ff, dy_in, dx_ff, dx_in;
   logic       valid_ff, valid_in;
   pix_type    pix_ff, pix_in;
   logic       advance, dx_wrap, dy_wrap, is_last;
   logic [7:0] shifted;
   logic [5:0] x_sum;
   logic [1:0] pair;

   always_comb begin
      advance = job_valid && (!valid_ff || out_pop);
      dx_wrap = !cfg.dbl_w || dx_ff;
      dy_wrap = !cfg.dbl_h || dy_ff;
      is_last = dx_wrap && dy_wrap && (px_ff == 3'd7);
      job_done = advance && is_last;

      px_in = px_ff;
      dy_in = dy_ff;
      dx_in = dx_ff;
      if (advance) begin
         if (!dx_wrap) begin
            dx_in = 1'b1;
         end else begin
            dx_in = 1'b0;
            if (!cfg.multicolor) begin
               if (!dy_wrap) begin
                  dy_in = 1'b1;
               end else begin
                  dy_in = 1'b0;
                  px_in = px_ff + 3'd1;
               end
            end else if (!px_ff[0]) begin
               px_in[0] = 1'b1;
            end else begin
               px_in[0] = 1'b0;
               if (!dy_wrap) begin
                  dy_in = 1'b1;
               end else begin
                  dy_in      = 1'b0;
                  px_in[2:1] = px_ff[2:1] + 2'd1;
               end
            end
         end
      end

      shifted = job.data << (cfg.multicolor ? {px_ff[2:1], 1'b0} : px_ff);
      pair    = shifted[7:6];
      x_sum   = {job.col_lo, px_ff};

      pix_in.pos_x      = cfg.dbl_w ? {x_sum[4:0], dx_ff} : x_sum;
      pix_in.pos_y      = cfg.dbl_h ? {job.row_lo[4:0], dy_ff} : job.row_lo;
      pix_in.last       = is_last;
      pix_in.sprite_end = is_last && job.sprite_end;
      pix_in.color       = COLOR_BG;
      pix_in.foreground  = 1'b0;
      pix_in.transparent = 1'b0;
      if (cfg.multicolor) begin
         case (pair)
            2'b00: begin
               pix_in.color       = 8'd0;
               pix_in.transparent = 1'b1;
            end
            2'b01: pix_in.color = {4'd0, cfg.color_a};
            2'b10: begin
               pix_in.color      = {4'd0, cfg.spr_color};
               pix_in.foreground = 1'b1;
            end
            2'b11: begin
               pix_in.color      = {4'd0, cfg.color_b};
               pix_in.foreground = 1'b1;
            end
            default: pix_in.color = 8'd0;
         endcase
      end else if (shifted[7]) begin
         pix_in.color      = {4'd0, cfg.spr_color};
         pix_in.foreground = 1'b1;
      end

      valid_in  = advance ? 1'b1 : (out_pop ? 1'b0 : valid_ff);
      out_valid = valid_ff;
      out_pix   = pix_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pix_ff <= pix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff    <= 3'd0;
         dy_ff    <= 1'b0;
         dx_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         px_ff    <= px_in;
         dy_ff    <= dy_in;
         dx_ff    <= dx_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/sprite_pixel_expander.sv */
// Sprite pixel expander top level: control registers, front end, job queue
// and back end. Depends on spe_pkg, spe_front, spe_fifo, spe_back.
//
// Usage:
//  - Input queue: drive req_data_byte and req_sprite_start with req_push; a
//    beat is taken at an edge with req_push high and req_full low. Bytes
//    arrive row by row; req_sprite_start marks byte 0 of a sprite.
//  - Result queue: while rsp_empty is low the oldest pixel write is on the
//    rsp_ ports; it is taken at an edge with rsp_pop high.
//  - Control registers: csr_index/csr_wdata with csr_valid; csr_ready is
//    always high. Write them only while no write is pending.
//  - Each byte gives 8, 16 or 32 writes (single/double width and height).
//    The back end issues one write per cycle while its result is not held;
//    a two-beat queue lets the next bytes be taken meanwhile.
//  - The first write of a byte passes the job queue and then the registered
//    result stage before it shows on the rsp_ ports.
//  - A stalled result holds the back end; the queue then fills and raises
//    req_full. Reset empties both queues, zeroes the byte position and
//    loads the register reset values.
`default_nettype none
module sprite_pixel_expander #(
   parameter int SPRITE_ROWS   = spe_pkg::SPRITE_ROWS_DEF,
   parameter int BYTES_PER_ROW = spe_pkg::BYTES_PER_ROW_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic                          req_sprite_start,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [5:0]                         rsp_pos_x,
   output logic [5:0]                         rsp_pos_y,
   output logic [7:0]                         rsp_color,
   output logic                               rsp_foreground,
   output logic                               rsp_transparent,
   output logic                               rsp_last,
   output logic                               rsp_sprite_end,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [spe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [spe_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import spe_pkg::*;

   cfg_type cfg_ff, cfg_in;
   job_type front_job, head_job;
   pix_type out_pix;
   logic    fifo_push, fifo_empty, job_done, out_valid;

   always_comb begin
      csr_ready = 1'b1;
      cfg_in    = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MULTICOLOR: cfg_in.multicolor = csr_wdata[0];
            CSR_DBL_WIDTH:  cfg_in.dbl_w      = csr_wdata[0];
            CSR_DBL_HEIGHT: cfg_in.dbl_h      = csr_wdata[0];
            CSR_SPR_COLOR:  cfg_in.spr_color  = csr_wdata;
            CSR_COLOR_A:    cfg_in.color_a    = csr_wdata;
            CSR_COLOR_B:    cfg_in.color_b    = csr_wdata;
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.multicolor <= 1'b0;
         cfg_ff.dbl_w      <= 1'b0;
         cfg_ff.dbl_h      <= 1'b0;
         cfg_ff.spr_color  <= 4'd0;
         cfg_ff.color_a    <= COLOR_A_RST;
         cfg_ff.color_b    <= COLOR_B_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign fifo_push = req_push && !req_full;

   spe_front #(
      .SPRITE_ROWS   (SPRITE_ROWS),
      .BYTES_PER_ROW (BYTES_PER_ROW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (fifo_push),
      .data_byte    (req_data_byte),
      .sprite_start (req_sprite_start),
      .job          (front_job)
   );

   spe_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .push_job (front_job),
      .full     (req_full),
      .pop      (job_done),
      .empty    (fifo_empty),
      .head_job (head_job)
   );

   spe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (!fifo_empty),
      .job       (head_job),
      .job_done  (job_done),
      .out_valid (out_valid),
      .out_pop   (rsp_pop),
      .out_pix   (out_pix)
   );

   assign rsp_empty       = !out_valid;
   assign rsp_pos_x       = out_pix.pos_x;
   assign rsp_pos_y       = out_pix.pos_y;
   assign rsp_color       = out_pix.color;
   assign rsp_foreground  = out_pix.foreground;
   assign rsp_transparent = out_pix.transparent;
   assign rsp_last        = out_pix.last;
   assign rsp_sprite_end  = out_pix.sprite_end;

endmodule
`default_nettype wire

/* hdl/spe_checker.sv */
// Port-level checker for the sprite pixel expander, bound to the top level.
// Depends on sprite_pixel_expander_defines.svh.
`default_nettype none
`include "sprite_pixel_expander_defines.svh"
module spe_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [5:0] rsp_pos_x,
   input wire logic [5:0] rsp_pos_y,
   input wire logic [7:0] rsp_color,
   input wire logic       rsp_foreground,
   input wire logic       rsp_transparent,
   input wire logic       rsp_last,
   input wire logic       rsp_sprite_end
);

   `SPE_ASSERT_ALWAYS(a_reset_empty, (reset |=> rsp_empty), "result queue not empty after reset")
   `SPE_ASSERT(a_end_is_last, ((!rsp_empty && rsp_sprite_end) |-> rsp_last), "sprite end without last")
   `SPE_ASSERT(a_transparent, ((!rsp_empty && rsp_transparent) |-> (rsp_color == 8'd0 && !rsp_foreground)), "transparent beat with colour or priority")
   `SPE_ASSERT(a_hold, ((!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_color))), "stalled beat changed")

endmodule

bind sprite_pixel_expander spe_checker u_spe_checker (.*);
`default_nettype wire

/* tb/sv/spe_tb_pkg.sv */
// Pixel write scoreboard for the sprite pixel expander testbench: predicts the
// writes of every accepted byte and checks returned writes in order.
// Depends on spe_pkg.
package spe_tb_pkg;
   import spe_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int SPRITE_BYTES = SPRITE_ROWS_DEF * BYTES_PER_ROW_DEF;

   class pixel_scoreboard;
      cfg_type regs;
      int      byte_pos;
      pix_type writes_due[$];
      int      fails;

      function new();
         regs = '0;
         regs.color_a = COLOR_A_RST;
         regs.color_b = COLOR_B_RST;
         byte_pos = 0;
         fails = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_MULTICOLOR: regs.multicolor = val[0];
            CSR_DBL_WIDTH:  regs.dbl_w = val[0];
            CSR_DBL_HEIGHT: regs.dbl_h = val[0];
            CSR_SPR_COLOR:  regs.spr_color = val;
            CSR_COLOR_A:    regs.color_a = val;
            CSR_COLOR_B:    regs.color_b = val;
            default: ;
         endcase
      endfunction

      // expand one accepted byte into its pixel writes
      function void take_byte(logic [7:0] data, logic start);
         int pos, row, colb, xs, ys, nsrc, span, s, dy, sx, dx;
         logic [1:0] pair;
         pix_type w;
         pos = start ? 0 : byte_pos;
         if (pos >= SPRITE_BYTES) pos = 0;
         row = pos / BYTES_PER_ROW_DEF;
         colb = pos % BYTES_PER_ROW_DEF;
         xs = regs.dbl_w ? 2 : 1;
         ys = regs.dbl_h ? 2 : 1;
         nsrc = regs.multicolor ? 4 : 8;
         span = regs.multicolor ? 2 : 1;
         for (s = 0; s < nsrc; s++) begin
            w = '0;
            if (regs.multicolor) begin
               pair = 2'((data >> (6 - 2 * s)) & 8'h03);
               case (pair)
                  2'b00: w.transparent = 1'b1;
                  2'b01: w.color = {4'h0, regs.color_a};
                  2'b10: begin
                     w.color = {4'h0, regs.spr_color};
                     w.foreground = 1'b1;
                  end
                  default: begin
                     w.color = {4'h0, regs.color_b};
                     w.foreground = 1'b1;
                  end
               endcase
            end else if (data[7 - s]) begin
               w.color = {4'h0, regs.spr_color};
               w.foreground = 1'b1;
            end else begin
               w.color = COLOR_BG;
            end
            for (dy = 0; dy < ys; dy++)
               for (sx = 0; sx < span; sx++)
                  for (dx = 0; dx < xs; dx++) begin
                     w.pos_x = 6'((colb * 8 + s * span + sx) * xs + dx);
                     w.pos_y = 6'(row * ys + dy);
                     writes_due.push_back(w);
                  end
         end
         writes_due[writes_due.size() - 1].last = 1'b1;
         if (pos == SPRITE_BYTES - 1) writes_due[writes_due.size() - 1].sprite_end = 1'b1;
         byte_pos = (pos + 1 >= SPRITE_BYTES) ? 0 : pos + 1;
      endfunction

      function void match(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
         end
      endfunction

      function void check_write(pix_type got);
         pix_type want;
         if (writes_due.size() == 0) begin
            $error("unexpected pixel write at x=%0d y=%0d", got.pos_x, got.pos_y);
            fails++;
            return;
         end
         want = writes_due.pop_front();
         match("pos_x", 8'(want.pos_x), 8'(got.pos_x));
         match("pos_y", 8'(want.pos_y), 8'(got.pos_y));
         match("color", want.color, got.color);
         match("foreground", 8'(want.foreground), 8'(got.foreground));
         match("transparent", 8'(want.transparent), 8'(got.transparent));
         match("last", 8'(want.last), 8'(got.last));
         match("sprite_end", 8'(want.sprite_end), 8'(got.sprite_end));
      endfunction
   endclass
endpackage

/* tb/sv/sprite_pixel_expander_tb.sv */
// Top-level testbench for sprite_pixel_expander: directed and random sprite
// bytes under varied control settings, with random stalls on both queues.
// Depends on spe_pkg, spe_tb_pkg and the sprite_pixel_expander RTL.
module sprite_pixel_expander_tb;
   import spe_pkg::*;
   import spe_tb_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 400;
   localparam int PHASE_BYTES = 65;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [7:0] req_data_byte = '0;
   logic req_sprite_start = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [5:0] rsp_pos_x, rsp_pos_y;
   logic [7:0] rsp_color;
   logic rsp_foreground, rsp_transparent, rsp_last, rsp_sprite_end;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit steady = 1'b0;
   bit hold_rsp = 1'b0;
   pixel_scoreboard sb = new();

   always #6 clock = ~clock;

   sprite_pixel_expander u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_data_byte(req_data_byte), .req_sprite_start(req_sprite_start),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_color(rsp_color),
      .rsp_foreground(rsp_foreground), .rsp_transparent(rsp_transparent),
      .rsp_last(rsp_last), .rsp_sprite_end(rsp_sprite_end),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic push_byte(logic [7:0] data, logic start);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_push <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= data;
      req_sprite_start <= start;
      do @(posedge clock); while (req_full);
      sb.take_byte(data, start);
   endtask

   // stop offering and wait for every outstanding write
   task automatic drain();
      req_push <= 1'b0;
      while (sb.writes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
   endtask

   // upper bits of single-bit registers are junk to check masking
   task automatic configure(cfg_type c);
      logic [3:0] junk;
      junk = 4'($urandom);
      write_reg(CSR_MULTICOLOR, {junk[3:1], c.multicolor});
      write_reg(CSR_DBL_WIDTH, {junk[2:0], c.dbl_w});
      write_reg(CSR_DBL_HEIGHT, {junk[1:0], junk[3], c.dbl_h});
      write_reg(CSR_SPR_COLOR, c.spr_color);
      write_reg(CSR_COLOR_A, c.color_a);
      write_reg(CSR_COLOR_B, c.color_b);
      write_reg($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, 4'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.multicolor = 1'($urandom_range(0, 1));
      c.dbl_w = 1'($urandom_range(0, 1));
      c.dbl_h = 1'($urandom_range(0, 1));
      c.spr_color = 4'($urandom_range(0, 15));
      c.color_a = 4'($urandom_range(0, 15));
      c.color_b = 4'($urandom_range(0, 15));
      return c;
   endfunction

   // result side
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = gap_len();
         if (hold_rsp) begin
            n = LONG_HOLD;
            hold_rsp = 1'b0;
         end
         if (n > 0) begin
            rsp_pop <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         if (!rsp_empty)
            sb.check_write(pix_type'{rsp_pos_x, rsp_pos_y, rsp_color, rsp_foreground,
                                     rsp_transparent, rsp_last, rsp_sprite_end});
      end
   end

   // watchdog on cycles with no beat on any channel
   initial begin
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int p, k;
      cfg_type c;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: single colour, no doubling
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'hA5, 1'b0);
      drain();
      configure('{1'b1, 1'b1, 1'b1, 4'hF, 4'hF, 4'hF});
      push_byte(8'h1B, 1'b1);
      push_byte(8'hE4, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h55, 1'b1);
      drain();
      configure('{1'b1, 1'b0, 1'b0, 4'h0, 4'h0, 4'h0});
      push_byte(8'h1B, 1'b0);
      push_byte(8'hC6, 1'b0);
      drain();
      configure('{1'b0, 1'b1, 1'b0, 4'hF, 4'h0, 4'hF});
      push_byte(8'h81, 1'b1);
      push_byte(8'h7E, 1'b0);
      drain();
      configure('{1'b1, 1'b0, 1'b1, 4'h5, 4'hA, 4'h3});
      push_byte(8'h1B, 1'b0);
      push_byte(8'hAA, 1'b0);
      drain();

      // random sprites; phase 0 runs past the last byte without a restart
      for (p = 0; p < 4; p++) begin
         drain();
         configure(random_cfg());
         steady = (p == 2);
         if (p == 1) hold_rsp = 1'b1;
         for (k = 0; k < PHASE_BYTES; k++)
            push_byte(8'($urandom_range(0, 255)),
                      (k == 0 && p != 3) || (p != 0 && $urandom_range(0, 19) == 0));
      end
      steady = 1'b0;
      drain();
      repeat (40) @(posedge clock);

      if (sb.fails == 0 && sb.writes_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
